// File: hw/rtl/smm_pkg.sv
// smm_pkg: shared types and constants of the stick-to-motor mixer.
// Used by smm_front, smm_queue, smm_back and stick_to_motor_mixer.
package smm_pkg;

	localparam int REG_IDX_W = 3;
	localparam int BAND_W = 10;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THROTTLE_FLOOR = 3'd0,
		REG_LIFT_MIN       = 3'd1,
		REG_LIFT_MAX       = 3'd2,
		REG_PITCH_MIN      = 3'd3,
		REG_PITCH_MAX      = 3'd4,
		REG_YAW_MIN        = 3'd5,
		REG_YAW_MAX        = 3'd6,
		REG_DEAD_BAND      = 3'd7
	} smm_reg_t;

	localparam logic [15:0] RST_FLOOR = 16'd1000;
	localparam logic [15:0] RST_MIN = 16'd1000;
	localparam logic [15:0] RST_MAX = 16'd2000;
	localparam logic [BAND_W-1:0] RST_BAND = 10'd50;

	// up: lift above band, dn: lift below band, dz: zero divisor, neg: negative quotient
	typedef struct packed {
		logic up;
		logic dn;
		logic dz;
		logic neg;
	} smm_ctl_t;

endpackage

// File: hw/rtl/stick_to_motor_mixer.sv
// channel | dir | handshake          | payload
// sticks  | in  | s_tvalid/s_tready  | s_tdata: armed, throttle, lift, pitch, yaw
// drives  | out | m_tvalid/m_tready  | m_tdata: eight motor pulse widths
// config  | in  | cfg_we             | cfg_index, cfg_data
// One item per cycle sustained while m_tready stays high. With an empty queue an item passes
// the front register, the queue, one stage per quotient bit of the lift divider, the output register.
// Reset (arst_n low) clears all valids and loads the calibration defaults.
// A stalled output stalls the divide pipeline; the four-entry queue then absorbs
// the front until it fills, and s_tready falls.
// Top level of the stick-to-motor mixer; depends on smm_pkg, smm_front,
// smm_queue and smm_back.
module stick_to_motor_mixer import smm_pkg::*; #(
	parameter int PULSE_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// armed, throttle_stick, lift_stick, pitch_stick, yaw_stick, zero pad
	input  logic [((4*PULSE_BITS+8)/8)*8-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// thrust, lift, left_antilift, right_antilift, left_yaw, right_yaw, pitch_up, pitch_down
	output logic [8*PULSE_BITS-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [((PULSE_BITS > BAND_W) ? PULSE_BITS : BAND_W)-1:0] cfg_data
);

	localparam int P = PULSE_BITS;
	localparam int CW = (P > BAND_W) ? P : BAND_W;
	localparam int QW = $bits(smm_ctl_t) + 9 * P;

	logic           f_valid, f_ready;
	smm_ctl_t       f_ctl;
	logic [2*P-1:0] f_prod;
	logic [P-1:0]   f_dmag, f_base, f_thr, f_ly, f_ry, f_pu, f_pd;

	logic           q_valid, q_ready;
	logic [QW-1:0]  q_data;
	smm_ctl_t       q_ctl;
	logic [2*P-1:0] q_prod;
	logic [P-1:0]   q_dmag, q_base;
	logic [5*P-1:0] q_pass;

	smm_front #(.P(P), .CW(CW)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.stick_valid    (s_tvalid),
		.stick_ready    (s_tready),
		.armed          (s_tdata[0]),
		.throttle_stick (s_tdata[P:1]),
		.lift_stick     (s_tdata[2*P:P+1]),
		.pitch_stick    (s_tdata[3*P:2*P+1]),
		.yaw_stick      (s_tdata[4*P:3*P+1]),
		.op_valid       (f_valid),
		.op_ready       (f_ready),
		.op_ctl         (f_ctl),
		.op_prod        (f_prod),
		.op_dmag        (f_dmag),
		.op_base        (f_base),
		.op_thrust      (f_thr),
		.op_left_yaw    (f_ly),
		.op_right_yaw   (f_ry),
		.op_pitch_up    (f_pu),
		.op_pitch_down  (f_pd)
	);

	smm_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_ctl, f_prod, f_dmag, f_base, f_pd, f_pu, f_ry, f_ly, f_thr}),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	assign {q_ctl, q_prod, q_dmag, q_base, q_pass} = q_data;

	smm_back #(.P(P)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (q_valid),
		.op_ready    (q_ready),
		.op_ctl      (q_ctl),
		.op_prod     (q_prod),
		.op_dmag     (q_dmag),
		.op_base     (q_base),
		.op_pass     (q_pass),
		.drive_valid (m_tvalid),
		.drive_ready (m_tready),
		.drives      (m_tdata)
	);

endmodule

// File: hw/rtl/smm_front.sv
// smm_front: configuration registers, stick classification and divide operands.
// Depends on smm_pkg; feeds smm_queue.
module smm_front import smm_pkg::*; #(
	parameter int P = 12,
	parameter int CW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CW-1:0]        cfg_data,
	input  logic                 stick_valid,
	output logic                 stick_ready,
	input  logic                 armed,
	input  logic [P-1:0]         throttle_stick,
	input  logic [P-1:0]         lift_stick,
	input  logic [P-1:0]         pitch_stick,
	input  logic [P-1:0]         yaw_stick,
	output logic                 op_valid,
	input  logic                 op_ready,
	output smm_ctl_t             op_ctl,
	output logic [2*P-1:0]       op_prod,
	output logic [P-1:0]         op_dmag,
	output logic [P-1:0]         op_base,
	output logic [P-1:0]         op_thrust,
	output logic [P-1:0]         op_left_yaw,
	output logic [P-1:0]         op_right_yaw,
	output logic [P-1:0]         op_pitch_up,
	output logic [P-1:0]         op_pitch_down
);

	localparam int BW = ((P > BAND_W) ? P : BAND_W) + 1;

	logic [P-1:0]      floor_q, lift_min_q, lift_max_q, pitch_min_q, pitch_max_q;
	logic [P-1:0]      yaw_min_q, yaw_max_q;
	logic [BAND_W-1:0] band_q;

	function automatic logic [2*P-1:0] pair_drive(input logic [P-1:0] stick,
		input logic [P-1:0] lo, input logic [P-1:0] hi, input logic [BAND_W-1:0] band);
		logic [P:0]   sum;
		logic [P-1:0] mid;
		logic [BW-1:0] s_w, m_w, b_w;
		logic [P+2:0] v;
		logic [P-1:0] above, below;
		sum = {1'b0, lo} + {1'b0, hi};
		mid = sum[P:1];
		s_w = BW'(stick);
		m_w = BW'(mid);
		b_w = BW'(band);
		above = lo;
		below = lo;
		if (s_w > m_w + b_w) begin
			v = (((P+3)'(stick) - (P+3)'(mid)) << 1) + (P+3)'(lo);
			above = (|v[P+2:P]) ? {P{1'b1}} : v[P-1:0];
		end else if (s_w + b_w < m_w) begin
			v = (((P+3)'(mid) - (P+3)'(stick)) << 1) + (P+3)'(lo);
			below = (|v[P+2:P]) ? {P{1'b1}} : v[P-1:0];
		end
		return {above, below};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= RST_FLOOR[P-1:0];
			lift_min_q  <= RST_MIN[P-1:0];
			lift_max_q  <= RST_MAX[P-1:0];
			pitch_min_q <= RST_MIN[P-1:0];
			pitch_max_q <= RST_MAX[P-1:0];
			yaw_min_q   <= RST_MIN[P-1:0];
			yaw_max_q   <= RST_MAX[P-1:0];
			band_q      <= RST_BAND;
		end else if (cfg_we) begin
			case (smm_reg_t'(cfg_index))
				REG_THROTTLE_FLOOR: floor_q <= cfg_data[P-1:0];
				REG_LIFT_MIN:       lift_min_q <= cfg_data[P-1:0];
				REG_LIFT_MAX:       lift_max_q <= cfg_data[P-1:0];
				REG_PITCH_MIN:      pitch_min_q <= cfg_data[P-1:0];
				REG_PITCH_MAX:      pitch_max_q <= cfg_data[P-1:0];
				REG_YAW_MIN:        yaw_min_q <= cfg_data[P-1:0];
				REG_YAW_MAX:        yaw_max_q <= cfg_data[P-1:0];
				REG_DEAD_BAND:      band_q <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	logic [P:0]     lsum;
	logic [P-1:0]   lmid;
	logic [BW-1:0]  lift_w, lmid_w, band_w;
	smm_ctl_t       ctl_d;
	logic [P-1:0]   off_d, smag_d, dmag_d;
	logic           sneg, dneg;
	logic [2*P-1:0] yaw_pair, pitch_pair;

	always_comb begin
		lsum = {1'b0, lift_min_q} + {1'b0, lift_max_q};
		lmid = lsum[P:1];
		lift_w = BW'(lift_stick);
		lmid_w = BW'(lmid);
		band_w = BW'(band_q);
		sneg = lift_min_q > lift_max_q;
		smag_d = sneg ? lift_min_q - lift_max_q : lift_max_q - lift_min_q;
		ctl_d.up = armed && (lift_w > lmid_w + band_w);
		ctl_d.dn = armed && (lift_w + band_w < lmid_w);
		off_d = '0;
		dneg = 1'b0;
		dmag_d = '0;
		if (ctl_d.up) begin
			off_d = lift_stick - lmid;
			dneg = lmid > lift_max_q;
			dmag_d = dneg ? lmid - lift_max_q : lift_max_q - lmid;
		end else if (ctl_d.dn) begin
			off_d = lmid - lift_stick;
			dneg = lift_min_q > lmid;
			dmag_d = dneg ? lift_min_q - lmid : lmid - lift_min_q;
		end
		ctl_d.dz = dmag_d == '0;
		ctl_d.neg = sneg ^ dneg;
		yaw_pair = pair_drive(yaw_stick, yaw_min_q, yaw_max_q, band_q);
		pitch_pair = pair_drive(pitch_stick, pitch_min_q, pitch_max_q, band_q);
	end

	logic           v_s1;
	smm_ctl_t       ctl_s1;
	logic [P-1:0]   off_s1, smag_s1, dmag_s1, base_s1, thr_s1, ly_s1, ry_s1, pu_s1, pd_s1;
	logic           take;

	assign stick_ready = !v_s1 || op_ready;
	assign take = stick_valid && stick_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (op_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1  <= ctl_d;
			off_s1  <= off_d;
			smag_s1 <= smag_d;
			dmag_s1 <= dmag_d;
			base_s1 <= armed ? lift_min_q : floor_q;
			thr_s1  <= armed ? throttle_stick : floor_q;
			ly_s1   <= armed ? yaw_pair[P-1:0] : floor_q;
			ry_s1   <= armed ? yaw_pair[2*P-1:P] : floor_q;
			pu_s1   <= armed ? pitch_pair[P-1:0] : floor_q;
			pd_s1   <= armed ? pitch_pair[2*P-1:P] : floor_q;
		end
	end

	assign op_valid      = v_s1;
	assign op_ctl        = ctl_s1;
	assign op_prod       = (2*P)'(off_s1) * (2*P)'(smag_s1);
	assign op_dmag       = dmag_s1;
	assign op_base       = base_s1;
	assign op_thrust     = thr_s1;
	assign op_left_yaw   = ly_s1;
	assign op_right_yaw  = ry_s1;
	assign op_pitch_up   = pu_s1;
	assign op_pitch_down = pd_s1;

`ifndef SYNTHESIS
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !op_ready |=> v_s1 && $stable(off_s1) && $stable(dmag_s1))
		else $error("front stage dropped a stalled item");
`endif

endmodule

// File: hw/rtl/smm_queue.sv
// smm_queue: short register FIFO between the front and the divide pipeline.
// Depends on smm_pkg for its depth.
module smm_queue import smm_pkg::*; #(
	parameter int W = 112
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			if (pop) rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
`endif

endmodule

// File: hw/rtl/smm_back.sv
// smm_back: restoring divide pipeline, one quotient bit per stage, then clamp and output.
// Depends on smm_pkg; takes items from smm_queue.
module smm_back import smm_pkg::*; #(
	parameter int P = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	output logic           op_ready,
	input  smm_ctl_t       op_ctl,
	input  logic [2*P-1:0] op_prod,
	input  logic [P-1:0]   op_dmag,
	input  logic [P-1:0]   op_base,
	input  logic [5*P-1:0] op_pass,
	output logic           drive_valid,
	input  logic           drive_ready,
	output logic [8*P-1:0] drives
);

	localparam int ND = 2 * P;

	logic           v_s    [ND];
	smm_ctl_t       ctl_s  [ND];
	logic [P-1:0]   rem_s  [ND];
	logic [2*P-1:0] num_s  [ND];
	logic [P-1:0]   d_s    [ND];
	logic [P-1:0]   base_s [ND];
	logic [5*P-1:0] pass_s [ND];

	logic           src_v    [ND];
	smm_ctl_t       src_ctl  [ND];
	logic [P-1:0]   src_rem  [ND];
	logic [2*P-1:0] src_num  [ND];
	logic [P-1:0]   src_d    [ND];
	logic [P-1:0]   src_base [ND];
	logic [5*P-1:0] src_pass [ND];
	logic [P:0]     trial    [ND];
	logic           ge       [ND];

	logic adv;
	logic v_out_q;
	logic [8*P-1:0] out_q;

	assign adv = !v_out_q || drive_ready;
	assign op_ready = adv;

	always_comb begin
		src_v[0]    = op_valid;
		src_ctl[0]  = op_ctl;
		src_rem[0]  = '0;
		src_num[0]  = op_prod;
		src_d[0]    = op_dmag;
		src_base[0] = op_base;
		src_pass[0] = op_pass;
		for (int k = 1; k < ND; k++) begin
			src_v[k]    = v_s[k-1];
			src_ctl[k]  = ctl_s[k-1];
			src_rem[k]  = rem_s[k-1];
			src_num[k]  = num_s[k-1];
			src_d[k]    = d_s[k-1];
			src_base[k] = base_s[k-1];
			src_pass[k] = pass_s[k-1];
		end
		for (int k = 0; k < ND; k++) begin
			trial[k] = {src_rem[k], src_num[k][2*P-1]};
			ge[k] = trial[k] >= {1'b0, src_d[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ND; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			for (int k = 0; k < ND; k++) v_s[k] <= src_v[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < ND; k++) begin
				ctl_s[k]  <= src_ctl[k];
				rem_s[k]  <= ge[k] ? P'(trial[k] - {1'b0, src_d[k]}) : trial[k][P-1:0];
				num_s[k]  <= {src_num[k][2*P-2:0], ge[k]};
				d_s[k]    <= src_d[k];
				base_s[k] <= src_base[k];
				pass_s[k] <= src_pass[k];
			end
		end
	end

	smm_ctl_t       fctl;
	logic [2*P-1:0] quo;
	logic [P-1:0]   base, scaled, lift_d, anti_d;
	logic [P+2:0]   sum;
	logic           ovf;

	always_comb begin
		fctl = ctl_s[ND-1];
		quo  = num_s[ND-1];
		base = base_s[ND-1];
		ovf  = |quo[2*P-1:P+1];
		sum  = fctl.neg ? (P+3)'(base) - (P+3)'(quo[P:0]) : (P+3)'(base) + (P+3)'(quo[P:0]);
		if (ovf) begin
			scaled = fctl.neg ? '0 : {P{1'b1}};
		end else if (sum[P+2]) begin
			scaled = '0;
		end else if (|sum[P+1:P]) begin
			scaled = {P{1'b1}};
		end else begin
			scaled = sum[P-1:0];
		end
		if (fctl.dz) scaled = base;
		lift_d = fctl.up ? scaled : base;
		anti_d = fctl.dn ? scaled : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (adv) begin
			v_out_q <= v_s[ND-1];
		end
	end

	// pass order from low bits: thrust, left yaw, right yaw, pitch up, pitch down
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {pass_s[ND-1][5*P-1:P], anti_d, anti_d, lift_d, pass_s[ND-1][P-1:0]};
		end
	end

	assign drive_valid = v_out_q;
	assign drives = out_q;

`ifndef SYNTHESIS
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ND-1] && adv |=> v_out_q)
		else $error("divide result lost before output register");
`endif

endmodule
